// File: hdl/spectral_bin_bend_top_defines.svh
// Assertion helpers shared by the checking code of the bender.
`ifndef SPECTRAL_BIN_BEND_TOP_DEFINES_SVH
`define SPECTRAL_BIN_BEND_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define SBB_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbb: check failed");

// Condition holds in the cycle after the trigger.
`define SBB_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbb: check failed");

`endif

// File: hdl/sbb_pkg.sv
package sbb_pkg;

  localparam int COEF_BITS  = 24;
  localparam int MAG_W      = COEF_BITS - 1;
  localparam int BIN_W      = 10;
  localparam int BLK_W      = 2;
  localparam int NUM_BLOCKS = 4;
  localparam int ADDR_W     = 12;
  localparam int GAIN_W     = 17;
  localparam int SHIFT_W    = 11;
  localparam int LEVEL_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = GAIN_W + 1 + MAG_W + 1;

  localparam logic [MAG_W-1:0]  MAG_MAX  = '1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_SHIFT     = 2'd0,
    CFG_LEVEL_SHIFT   = 2'd1,
    CFG_FEEDBACK_GAIN = 2'd2
  } sbb_cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coefficient;
    logic [BIN_W-1:0]            bin_index;
    logic [BLK_W-1:0]            block_index;
  } sbb_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]            out_bin;
    logic [BLK_W-1:0]            out_block;
    logic signed [COEF_BITS-1:0] bent_value;
  } sbb_out_t;

  // One item on its way into the smoother pipeline.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BIN_W-1:0]  dst;
    logic [BLK_W-1:0]  blk;
    logic [MAG_W-1:0]  mag;
    logic              pos;
  } sbb_issue_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [MAG_W-1:0]  data;
  } sbb_wr_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
  } sbb_slot_t;

endpackage

// File: hdl/sbb_store.sv
module sbb_store import sbb_pkg::*; #(
  parameter int DEPTH = 2304
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [MAG_W-1:0]  rd_data,
  input  sbb_wr_t           wr
);

  localparam int AW = $clog2(DEPTH);

  logic [MAG_W-1:0] mem [DEPTH];
  logic [MAG_W-1:0] rd_data_r;

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/sbb_smooth.sv
module sbb_smooth import sbb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [GAIN_W-1:0] gain,
  input  logic              iss_vld,
  input  sbb_issue_t        iss,
  input  logic [MAG_W-1:0]  rd_data,
  input  logic              out_stall,
  output logic              out_valid,
  output sbb_out_t          out_data,
  output logic              adv,
  output sbb_slot_t         s1_slot,
  output sbb_wr_t           wr
);

  logic                     s1_vld_r, s2_vld_r, s3_vld_r, out_valid_r;
  sbb_issue_t               s1_r, s2_r, s3_r;
  logic signed [MAG_W:0]    s2_diff_r;
  logic signed [PROD_W-1:0] s3_prod_r;
  logic                     wb_vld_r;
  logic [ADDR_W-1:0]        wb_addr_r;
  logic [MAG_W-1:0]         wb_data_r;
  sbb_out_t                 out_r;

  logic [MAG_W-1:0]         s1_old;
  logic signed [MAG_W:0]    s2_diff_nxt;
  logic signed [PROD_W-1:0] s3_prod_nxt;
  logic signed [PROD_W-1:0] s3_rnd, s3_sum;
  logic [MAG_W-1:0]         s3_new;
  logic [COEF_BITS-1:0]     s3_ext;
  sbb_out_t                 out_nxt;

  assign adv = !out_valid_r || !out_stall;

  // new = mag + round(g * (old - mag) / 2^16), same as the convex mix
  always_comb begin
    s3_rnd = (s3_prod_r + $signed(RND_HALF)) >>> FRAC_W;
    s3_sum = s3_rnd + $signed(PROD_W'(s3_r.mag));
    s3_new = s3_sum[MAG_W-1:0];
  end

  // Take the newest value of the entry: write stage, last write, then memory.
  always_comb begin
    if (s3_vld_r && s3_r.addr == s1_r.addr) begin
      s1_old = s3_new;
    end else if (wb_vld_r && wb_addr_r == s1_r.addr) begin
      s1_old = wb_data_r;
    end else begin
      s1_old = rd_data;
    end
    s2_diff_nxt = $signed({1'b0, s1_old}) - $signed({1'b0, s1_r.mag});
  end

  assign s3_prod_nxt = $signed({1'b0, gain}) * s2_diff_r;

  always_comb begin
    s3_ext = {1'b0, s3_new};
    out_nxt.out_bin    = s3_r.dst;
    out_nxt.out_block  = s3_r.blk;
    out_nxt.bent_value = s3_r.pos ? $signed(s3_ext) : $signed(-s3_ext);
  end

  assign wr      = '{en: s3_vld_r && adv, addr: s3_r.addr, data: s3_new};
  assign s1_slot = '{vld: s1_vld_r, addr: s1_r.addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      wb_vld_r    <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_r    <= iss_vld;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        out_valid_r <= s3_vld_r;
      end
      if (wr.en) begin
        wb_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= iss;
      s2_r      <= s1_r;
      s2_diff_r <= s2_diff_nxt;
      s3_r      <= s2_r;
      s3_prod_r <= s3_prod_nxt;
      out_r     <= out_nxt;
    end
    if (wr.en) begin
      wb_addr_r <= wr.addr;
      wb_data_r <= wr.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/spectral_bin_bend_top.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  sbb_in_t   coefficient, bin_index, block_index
// out_      output     out_valid/out_stall sbb_out_t out_bin, out_block, bent_value
// cfg_      input      cfg_valid/cfg_ready index + data, registers 0..2
//
// One item per cycle when not stalled; an accepted item passes s1, s2, s3 and
// the output register. Two back-to-back items to the same block and bin leave
// a bubble: the store read-modify-write loop through the multiplier spans two
// stages. After reset a clearing pass zeroes all NUM_BLOCKS * NUM_BINS entries
// (2304 by default); in_stall stays high meanwhile, configuration is taken.
// out_stall freezes the pipeline; the input register still takes one item.
`include "spectral_bin_bend_top_defines.svh"

module spectral_bin_bend_top import sbb_pkg::*; #(
  parameter int NUM_BINS = 576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sbb_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbb_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = NUM_BLOCKS * NUM_BINS;
  localparam int SH_OFS = (NUM_BINS - (1024 % NUM_BINS)) % NUM_BINS;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  // Reduce a value below 32 * NUM_BINS, one conditional subtract per step.
  function automatic logic [BIN_W-1:0] bin_mod(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (r >= 16'(NUM_BINS << k)) begin
        r = r - 16'(NUM_BINS << k);
      end
    end
    return r[BIN_W-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [BIN_W-1:0]   shift_r, shift_nxt;
  logic [LEVEL_W-1:0] level_r;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [SHIFT_W-1:0] sh_t;
  logic [BIN_W-1:0]   sh_m;
  logic [BIN_W:0]     sh_sum, sh_sub;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Bias the signed shift to unsigned, reduce, then remove the bias mod NUM_BINS.
  always_comb begin
    sh_t   = {~cfg_data[SHIFT_W-1], cfg_data[SHIFT_W-2:0]};
    sh_m   = bin_mod(16'(sh_t));
    sh_sum = {1'b0, sh_m} + (BIN_W + 1)'(SH_OFS);
    sh_sub = sh_sum - (BIN_W + 1)'(NUM_BINS);
    shift_nxt = (sh_sum >= (BIN_W + 1)'(NUM_BINS)) ? sh_sub[BIN_W-1:0] : sh_sum[BIN_W-1:0];
    gain_nxt  = (cfg_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      level_r <= '0;
      gain_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN_SHIFT:     shift_r <= shift_nxt;
        CFG_LEVEL_SHIFT:   level_r <= cfg_data[LEVEL_W-1:0];
        CFG_FEEDBACK_GAIN: gain_r  <= gain_nxt;
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass ----------------
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // ---------------- input register and issue ----------------
  logic              s0_vld_r;
  sbb_in_t           s0_r;
  logic              in_acc, s0_go, hz, adv;
  sbb_slot_t         s1_slot;
  sbb_issue_t        iss;
  sbb_wr_t           wr_pipe, wr_mem;
  logic [MAG_W-1:0]  rd_data;

  logic                 neg, nz, lneg, lpos, zeroed;
  logic [COEF_BITS-1:0] cw, absx, negl;
  logic [COEF_BITS:0]   m_sum, m_bent;
  logic [BIN_W-1:0]     src_bin, dst;
  logic [BIN_W:0]       d_sum, d_sub;
  logic [ADDR_W-1:0]    s0_addr;

  // Bend the magnitude (saturating at MAG_MAX): positive offset adds, negative offset is a dead zone.
  always_comb begin
    cw     = s0_r.coefficient;
    neg    = cw[COEF_BITS-1];
    absx   = neg ? (~cw + 1'b1) : cw;
    nz     = (absx != '0);
    lneg   = level_r[LEVEL_W-1];
    lpos   = !lneg && (level_r != '0);
    negl   = ~level_r + 1'b1;
    m_sum  = {1'b0, absx} + {1'b0, level_r};
    m_bent = {1'b0, absx};
    zeroed = 1'b0;
    if (lpos && nz) begin
      m_bent = m_sum;
    end else if (lneg && absx < negl) begin
      m_bent = '0;
      zeroed = 1'b1;
    end
    iss.mag  = (m_bent > (COEF_BITS + 1)'(MAG_MAX)) ? MAG_MAX : m_bent[MAG_W-1:0];
    iss.pos  = !neg && nz && !zeroed;
    iss.addr = s0_addr;
    iss.dst  = dst;
    iss.blk  = s0_r.block_index;
  end

  always_comb begin
    src_bin = bin_mod(16'(s0_r.bin_index));
    d_sum   = {1'b0, src_bin} + {1'b0, shift_r};
    d_sub   = d_sum - (BIN_W + 1)'(NUM_BINS);
    dst     = (d_sum >= (BIN_W + 1)'(NUM_BINS)) ? d_sub[BIN_W-1:0] : d_sum[BIN_W-1:0];
    s0_addr = ADDR_W'(s0_r.block_index) * ADDR_W'(NUM_BINS) + ADDR_W'(dst);
  end

  // Hold back an item whose entry is still in s1, short of the write stage s3.
  assign hz       = s1_slot.vld && (s1_slot.addr == s0_addr);
  assign s0_go    = s0_vld_r && adv && !hz;
  assign in_stall = clr_busy_r || (s0_vld_r && !s0_go);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_acc) begin
      s0_vld_r <= 1'b1;
    end else if (s0_go) begin
      s0_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r <= in_data;
    end
  end

  assign wr_mem = clr_busy_r ? sbb_wr_t'{en: 1'b1, addr: clr_addr_r, data: '0} : wr_pipe;

  sbb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (s0_go),
    .rd_addr (s0_addr),
    .rd_data (rd_data),
    .wr      (wr_mem)
  );

  sbb_smooth u_smooth (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .iss_vld   (s0_go),
    .iss       (iss),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .adv       (adv),
    .s1_slot   (s1_slot),
    .wr        (wr_pipe)
  );

  `SBB_CHECK_NOW(a_clr_no_pipe_write, clr_busy_r, !wr_pipe.en)
  `SBB_CHECK_NOW(a_clr_no_read, clr_busy_r, !s0_go)
  `SBB_CHECK_NEXT(a_clr_ends, clr_busy_r && clr_addr_r == CLR_LAST, !clr_busy_r)

endmodule
